@@ rtl/pcpd_pkg.sv @@
`timescale 1ns / 1ps
package pcpd_pkg;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         plane_slot;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] aux_x;
    logic signed [31:0] aux_y;
    logic signed [31:0] aux_z;
    logic signed [31:0] scalar;
  } pcpd_in_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic [3:0]         best_plane;
    logic               found;
    logic               early_out;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
  } pcpd_out_t;

  localparam logic [1:0] MODE_LOAD      = 2'd0;
  localparam logic [1:0] MODE_CONTACT   = 2'd1;
  localparam logic [1:0] MODE_COLLISION = 2'd2;
  localparam logic [1:0] MODE_SPHERE    = 2'd3;

  localparam logic REG_IS_HOLE     = 1'b0;
  localparam logic REG_PLANE_COUNT = 1'b1;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL,
    ST_SUM,
    ST_EVAL,
    ST_FIN,
    ST_CMUL,
    ST_CSUB,
    ST_OUT
  } pcpd_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return S32_MAX;
    if (v < -66'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

endpackage

@@ rtl/pcpd_ram.sv @@
`timescale 1ns / 1ps
module pcpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/point_convex_polytope_distance_core.sv @@
// Point / sphere to convex polytope signed distance. Face planes (normal and
// offset, Q16.16) sit in one 128-bit wide synchronous RAM, loaded by mode 0
// items. A query walks the faces one at a time (RAM read, six parallel 32x32
// products against the point and the aux vector, exact sum, evaluate); when a
// plane was found the contact point is formed after the walk; a sphere query
// stops at its first non-negative face. The result sits in an output register,
// and the next item can be taken in the cycle after the result has been taken,
// so queries do not overlap.
`timescale 1ns / 1ps
module point_convex_polytope_distance_core
  import pcpd_pkg::*;
#(
  parameter int MAX_PLANES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pcpd_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output pcpd_out_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [4:0] cfg_wdata
);
  localparam int AW = $clog2(MAX_PLANES);

  pcpd_state_t state_r, state_nxt;
  logic        is_hole_r;
  logic [4:0]  plane_count_r;
  pcpd_in_t    q_r;
  logic [AW:0] idx_r, lim_r;
  logic [AW:0] best_r;
  logic        found_r, early_r;
  logic signed [31:0] largest_r;
  logic signed [63:0] pa_r, pb_r, pc_r, va_r, vb_r, vc_r;
  logic signed [65:0] dp_r, sp_r;
  logic signed [31:0] dist_r;
  logic signed [31:0] bnx_r, bny_r, bnz_r;
  logic signed [63:0] cx_r, cy_r, cz_r;
  pcpd_out_t   out_r;
  logic        out_valid_r;

  logic [127:0] rdata;
  logic signed [31:0] nx, ny, nz, off;
  assign nx  = rdata[127:96];
  assign ny  = rdata[95:64];
  assign nz  = rdata[63:32];
  assign off = rdata[31:0];

  logic ram_we;
  assign ram_we = in_valid && in_ready && in_data.mode == MODE_LOAD
                  && ({28'd0, in_data.plane_slot} < MAX_PLANES);

  pcpd_ram #(.WIDTH(128), .DEPTH(MAX_PLANES)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_data.plane_slot)),
    .wdata({in_data.aux_x, in_data.aux_y, in_data.aux_z, in_data.scalar}),
    .raddr(idx_r[AW-1:0]),
    .rdata(rdata)
  );

  // exact floor of (a+b+c)/2^16: sum full products then arithmetic shift
  function automatic logic signed [65:0] fsum(input logic signed [63:0] a,
      input logic signed [63:0] b, input logic signed [63:0] c);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b) + 66'(c);
    return s >>> 16;
  endfunction

  logic signed [31:0] d_eval;
  logic take, larger, stop;
  always_comb begin
    if (q_r.mode == MODE_SPHERE) d_eval = sat32(dp_r - 66'(q_r.scalar));
    else d_eval = sat32(dp_r);
    larger = !found_r || d_eval > largest_r;
    stop   = q_r.mode == MODE_SPHERE && !d_eval[31];
    take   = 1'b1;
    if (q_r.mode == MODE_COLLISION)
      take = ((is_hole_r ? -sp_r : sp_r) <= 0) || !d_eval[31] || is_hole_r;
  end

  logic signed [31:0] dist_fin;
  always_comb begin
    if (!found_r) dist_fin = S32_MIN;
    else if (early_r || !is_hole_r) dist_fin = largest_r;
    else if (largest_r == S32_MIN) dist_fin = S32_MAX;
    else dist_fin = -largest_r;
  end

  function automatic logic signed [31:0] cc(input logic signed [31:0] p,
      input logic signed [63:0] prod, input logic hole);
    logic signed [65:0] t;
    t = 66'(prod) >>> 16;
    if (hole) t = -t;
    return sat32(66'(p) - t);
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready && in_data.mode != MODE_LOAD) state_nxt = ST_RD;
      ST_RD:   state_nxt = (idx_r >= lim_r) ? ST_FIN : ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = stop ? ST_FIN : ST_RD;
      ST_FIN:  state_nxt = found_r ? ST_CMUL : ST_OUT;
      ST_CMUL: state_nxt = ST_CSUB;
      ST_CSUB: state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = state_r == ST_IDLE && !out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      is_hole_r     <= 1'b0;
      plane_count_r <= 5'd6;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_IS_HOLE) is_hole_r <= cfg_wdata[0];
        else plane_count_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      else if (state_r == ST_OUT && !out_valid_r) out_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        q_r       <= in_data;
        idx_r     <= '0;
        found_r   <= 1'b0;
        early_r   <= 1'b0;
        best_r    <= '0;
        largest_r <= S32_MIN;
        if ({27'd0, plane_count_r} > MAX_PLANES) lim_r <= (AW+1)'(MAX_PLANES);
        else lim_r <= (AW+1)'(plane_count_r);
      end
      ST_MUL: begin
        pa_r <= nx * q_r.point_x;
        pb_r <= ny * q_r.point_y;
        pc_r <= nz * q_r.point_z;
        va_r <= nx * q_r.aux_x;
        vb_r <= ny * q_r.aux_y;
        vc_r <= nz * q_r.aux_z;
      end
      ST_SUM: begin
        dp_r <= fsum(pa_r, pb_r, pc_r) - 66'(off);
        sp_r <= fsum(va_r, vb_r, vc_r);
      end
      ST_EVAL: begin
        if (stop || (larger && take)) begin
          largest_r <= d_eval;
          best_r    <= idx_r;
          found_r   <= 1'b1;
          bnx_r     <= nx;
          bny_r     <= ny;
          bnz_r     <= nz;
        end
        if (stop) early_r <= 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      ST_FIN: dist_r <= dist_fin;
      ST_CMUL: begin
        cx_r <= bnx_r * dist_r;
        cy_r <= bny_r * dist_r;
        cz_r <= bnz_r * dist_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && !out_valid_r) begin
      out_r.distance   <= dist_r;
      out_r.best_plane <= 4'(best_r);
      out_r.found      <= found_r;
      out_r.early_out  <= early_r;
      out_r.contact_x  <= found_r ? cc(q_r.point_x, cx_r, is_hole_r) : q_r.point_x;
      out_r.contact_y  <= found_r ? cc(q_r.point_y, cy_r, is_hole_r) : q_r.point_y;
      out_r.contact_z  <= found_r ? cc(q_r.point_z, cz_r, is_hole_r) : q_r.point_z;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

@@ verif/point_convex_polytope_distance_core_tb.sv @@
`timescale 1ns / 1ps
module point_convex_polytope_distance_core_tb;
  import pcpd_pkg::*;

  localparam int NUM_FACES   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pcpd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pcpd_out_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = REG_IS_HOLE;
  logic [4:0] cfg_wdata = '0;

  point_convex_polytope_distance_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [31:0] face_nx [NUM_FACES];
  logic signed [31:0] face_ny [NUM_FACES];
  logic signed [31:0] face_nz [NUM_FACES];
  logic signed [31:0] face_off [NUM_FACES];
  logic       hole_cfg = 1'b0;
  logic [4:0] count_cfg = 5'd6;

  pcpd_out_t expected_results [$];
  int errors = 0;
  int cycle_count = 0;
  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int idle_mode = 0;
  int hold_cycles = 0;

  function automatic logic signed [31:0] clamp32(logic signed [66:0] v);
    if (v > 67'sd2147483647) return 32'sh7fffffff;
    if (v < -67'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // exact floor of the three-term Q32.32 sum, back to Q16.16
  function automatic logic signed [66:0] dot_q16(
      logic signed [31:0] ax, logic signed [31:0] ay, logic signed [31:0] az,
      logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] bz);
    logic signed [66:0] s;
    s = 67'(ax) * 67'(bx) + 67'(ay) * 67'(by) + 67'(az) * 67'(bz);
    return s >>> 16;
  endfunction

  function automatic logic signed [31:0] contact_of(logic signed [31:0] p,
      logic signed [31:0] nrm, logic signed [31:0] d);
    logic signed [66:0] t;
    t = (67'(nrm) * 67'(d)) >>> 16;
    if (hole_cfg) t = -t;
    return clamp32(67'(p) - t);
  endfunction

  // updates the face table for a load and returns 0; returns 1 and the result for a query
  function automatic bit predict_distance(pcpd_in_t it, output pcpd_out_t r);
    int n, best;
    bit found, early, take;
    logic signed [31:0] largest, d, dist_v;
    logic signed [66:0] dp, sp;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      face_nx[it.plane_slot] = it.aux_x;
      face_ny[it.plane_slot] = it.aux_y;
      face_nz[it.plane_slot] = it.aux_z;
      face_off[it.plane_slot] = it.scalar;
      return 0;
    end
    n = (count_cfg < NUM_FACES) ? count_cfg : NUM_FACES;
    best = 0; found = 0; early = 0; largest = S32_MIN;
    for (int i = 0; i < n; i++) begin
      dp = dot_q16(face_nx[i], face_ny[i], face_nz[i], it.point_x, it.point_y, it.point_z)
           - 67'(face_off[i]);
      if (it.mode == MODE_SPHERE) begin
        d = clamp32(dp - 67'(it.scalar));
        if (d >= 0) begin
          largest = d; best = i; found = 1; early = 1;
          break;
        end
      end else begin
        d = clamp32(dp);
      end
      if (!found || d > largest) begin
        take = 1;
        if (it.mode == MODE_COLLISION) begin
          sp = dot_q16(it.aux_x, it.aux_y, it.aux_z, face_nx[i], face_ny[i], face_nz[i]);
          if (hole_cfg) sp = -sp;
          take = (sp <= 0) || (d >= 0) || hole_cfg;
        end
        if (take) begin
          largest = d; best = i; found = 1;
        end
      end
    end
    if (!found) dist_v = S32_MIN;
    else if (early || !hole_cfg) dist_v = largest;
    else dist_v = (largest == S32_MIN) ? S32_MAX : -largest;
    r.distance = dist_v;
    r.best_plane = best[3:0];
    r.found = found;
    r.early_out = early;
    if (found) begin
      r.contact_x = contact_of(it.point_x, face_nx[best], dist_v);
      r.contact_y = contact_of(it.point_y, face_ny[best], dist_v);
      r.contact_z = contact_of(it.point_z, face_nz[best], dist_v);
    end else begin
      r.contact_x = it.point_x;
      r.contact_y = it.point_y;
      r.contact_z = it.point_z;
    end
    return 1;
  endfunction

  // value mix: extremes, zero, unit-scale, moderate and fully random
  function automatic logic signed [31:0] pick_value(int scale);
    case ($urandom_range(0, 9))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'sd0;
      3: return $urandom();
      4: return ($urandom_range(0, 1) ? 32'sd65536 : -32'sd65536);
      default: return $signed($urandom_range(0, 2 * scale)) - scale;
    endcase
  endfunction

  task automatic send_item(pcpd_in_t it);
    pcpd_out_t r;
    while ((idle_mode == 1 || idle_mode == 3) &&
           $urandom_range(0, 99) < ((idle_mode == 1) ? 68 : 17)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (predict_distance(it, r)) expected_results.push_back(r);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [4:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IS_HOLE) hole_cfg = val[0];
    else count_cfg = val;
  endtask

  function automatic pcpd_in_t random_item();
    pcpd_in_t it;
    it.mode = ($urandom_range(0, 3) == 0) ? MODE_LOAD : 2'($urandom_range(1, 3));
    it.plane_slot = 4'($urandom_range(0, 15));
    it.point_x = pick_value(1 << 20);
    it.point_y = pick_value(1 << 20);
    it.point_z = pick_value(1 << 20);
    it.aux_x = pick_value(1 << 17);
    it.aux_y = pick_value(1 << 17);
    it.aux_z = pick_value(1 << 17);
    it.scalar = pick_value(1 << 19);
    return it;
  endfunction

  task automatic test_directed();
    pcpd_in_t it;
    // all sixteen faces, extremes among them
    for (int i = 0; i < NUM_FACES; i++) begin
      it = random_item();
      it.mode = MODE_LOAD;
      it.plane_slot = 4'(i);
      if (i == 0) begin
        it.aux_x = 32'sd65536; it.aux_y = 0; it.aux_z = 0; it.scalar = 32'sd65536;
      end else if (i == 1) begin
        it.aux_x = S32_MAX; it.aux_y = S32_MAX; it.aux_z = S32_MAX; it.scalar = S32_MIN;
      end else if (i == 2) begin
        it.aux_x = S32_MIN; it.aux_y = S32_MIN; it.aux_z = S32_MIN; it.scalar = S32_MAX;
      end else if (i == 3) begin
        it.aux_x = 0; it.aux_y = 0; it.aux_z = 0; it.scalar = 0;
      end
      send_item(it);
    end
    for (int m = 1; m <= 3; m++) begin
      it = random_item();
      it.mode = 2'(m);
      it.point_x = S32_MAX; it.point_y = S32_MAX; it.point_z = S32_MAX;
      it.scalar = S32_MIN;
      send_item(it);
      it.point_x = S32_MIN; it.point_y = S32_MIN; it.point_z = S32_MIN;
      it.scalar = S32_MAX;
      it.aux_x = S32_MAX;
      send_item(it);
      it.point_x = 0; it.point_y = 0; it.point_z = 0; it.scalar = 0;
      send_item(it);
    end
    // zero faces: nothing qualifies
    cfg_write(REG_PLANE_COUNT, 5'd0);
    it = random_item();
    it.mode = MODE_CONTACT;
    send_item(it);
  endtask

  task automatic run_random(int items);
    for (int k = 0; k < items; k++) send_item(random_item());
  endtask

  task automatic test_settings_sweep();
    logic [4:0] counts [6] = '{5'd1, 5'd16, 5'd31, 5'd6, 5'd17, 5'd3};
    for (int s = 0; s < 6; s++) begin
      cfg_write(REG_IS_HOLE, s[0]);
      cfg_write(REG_PLANE_COUNT, counts[s]);
      idle_mode = s % 4;
      run_random(150);
    end
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(REG_IS_HOLE, 1'($urandom_range(0, 1)));
      cfg_write(REG_PLANE_COUNT, 5'($urandom_range(1, 16)));
      idle_mode = ph;
      run_random(200);
    end
  endtask

  task automatic test_backpressure();
    idle_mode = 0;
    cfg_write(REG_PLANE_COUNT, 5'd2);
    hold_cycles = 400;
    run_random(30);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (idle_mode >= 2) begin
      out_ready <= ($urandom_range(0, 99) >= ((idle_mode == 2) ? 68 : 17));
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pcpd_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: %p", out_data);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.distance !== e.distance) begin
          $error("distance: expected %0d, got %0d", e.distance, out_data.distance);
          errors++;
        end
        if (out_data.best_plane !== e.best_plane) begin
          $error("best_plane: expected %0d, got %0d", e.best_plane, out_data.best_plane);
          errors++;
        end
        if (out_data.found !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, out_data.found);
          errors++;
        end
        if (out_data.early_out !== e.early_out) begin
          $error("early_out: expected %0d, got %0d", e.early_out, out_data.early_out);
          errors++;
        end
        if (out_data.contact_x !== e.contact_x) begin
          $error("contact_x: expected %0d, got %0d", e.contact_x, out_data.contact_x);
          errors++;
        end
        if (out_data.contact_y !== e.contact_y) begin
          $error("contact_y: expected %0d, got %0d", e.contact_y, out_data.contact_y);
          errors++;
        end
        if (out_data.contact_z !== e.contact_z) begin
          $error("contact_z: expected %0d, got %0d", e.contact_z, out_data.contact_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_FACES; i++) begin
      face_nx[i] = 0; face_ny[i] = 0; face_nz[i] = 0; face_off[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings_sweep();
    test_backpressure();
    test_random_phases();
    drain();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
